// File: src/assert_macros.svh
// Assertion macros, clocked on clk and disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond must hold at every clock edge.
`define ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// ante at one edge implies cons at the same edge.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// ante at one edge implies cons at the next edge.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: src/sha1_pkg.sv
package sha1_pkg;

    typedef logic [31:0] word_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_ROUND,
        ST_ADD,
        ST_OUT
    } state_t;

    typedef enum logic [1:0] {
        PAD_MARK,
        PAD_ZERO,
        PAD_LEN,
        PAD_DONE
    } pad_kind_t;

    localparam int unsigned NUM_WORDS  = 5;
    localparam int unsigned NUM_ROUNDS = 80;

    localparam word_t H0_INIT = 32'h67452301;
    localparam word_t H1_INIT = 32'hEFCDAB89;
    localparam word_t H2_INIT = 32'h98BADCFE;
    localparam word_t H3_INIT = 32'h10325476;
    localparam word_t H4_INIT = 32'hC3D2E1F0;

    localparam logic [NUM_WORDS-1:0][31:0] H_INIT =
        {H4_INIT, H3_INIT, H2_INIT, H1_INIT, H0_INIT};

    localparam word_t K_0  = 32'h5A827999;
    localparam word_t K_20 = 32'h6ED9EBA1;
    localparam word_t K_40 = 32'h8F1BBCDC;
    localparam word_t K_60 = 32'hCA62C1D6;

    localparam logic [7:0] PAD_MARK_BYTE = 8'h80;
    localparam logic [5:0] LEN_BYTE_POS  = 6'd56;
    localparam logic [5:0] LAST_BYTE_POS = 6'd63;

    function automatic word_t rotl(input word_t x, input int unsigned r);
        rotl = (x << r) | (x >> (32 - r));
    endfunction

endpackage

// File: src/sha1_message_digest_unit.sv
// SHA-1 digest unit.
// Input stream (s_axis): one message byte per transaction. tdata is the byte,
// tuser flags it as a message byte, tlast ends the message. An item with tuser
// low and tlast high ends the message without adding a byte (empty message).
// Output stream (m_axis): five transactions per message, H0 first; tdata is the
// digest word, tuser its index 0..4, tlast marks H4.
// Flow: a byte that does not close a 64-byte block leaves the unit ready for
// the next byte. A byte that closes a block starts the round engine: 80 rounds
// at one per cycle, then the chaining add, with s_axis_tready low. On tlast the
// padding bytes, up to 72, go through the same byte path, one per cycle
// outside the one or two more compressions. The five digest words then follow,
// one per cycle while m_axis_tready is high.
// Each round uses the single 5-operand round adder.
// A stalled receiver holds the current word; no input is taken until all five
// words are delivered. Reset loads the SHA-1 initial values and clears the
// byte and length counters; the same happens after each digest.
`include "assert_macros.svh"

module sha1_message_digest_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // data_byte
    input  logic        s_axis_tuser,   // byte_valid
    input  logic        s_axis_tlast,   // last
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // digest_word
    output logic [2:0]  m_axis_tuser,   // word_index
    output logic        m_axis_tlast    // last_word
);

    sha1_pkg::state_t                 state_reg, state_next;
    sha1_pkg::pad_kind_t              pad_reg, pad_next;
    logic                             fin_reg, fin_next;
    logic [6:0]                       round_reg, round_next;
    logic [5:0]                       count_reg, count_next;
    logic [63:0]                      len_reg, len_next;
    logic [2:0]                       idx_reg, idx_next;
    logic [sha1_pkg::NUM_WORDS-1:0][31:0] hash_reg, hash_next;
    logic [511:0]                     sched_reg, sched_next;
    sha1_pkg::word_t                  a_reg, b_reg, c_reg, d_reg, e_reg;
    sha1_pkg::word_t                  a_next, b_next, c_next, d_next, e_next;

    logic                             push_en;
    logic [7:0]                       push_byte;
    sha1_pkg::word_t                  w_sel, f_val, k_val;

    // oldest schedule word sits in the top bits
    function automatic sha1_pkg::word_t sched_word(input logic [511:0] s,
                                                   input int unsigned i);
        sched_word = s[511 - 32*i -: 32];
    endfunction

    always_comb
    begin
        if (round_reg < 7'd16)
        begin
            w_sel = sched_word(sched_reg, 0);
        end
        else
        begin
            w_sel = sha1_pkg::rotl(sched_word(sched_reg, 13) ^ sched_word(sched_reg, 8)
                                 ^ sched_word(sched_reg, 2) ^ sched_word(sched_reg, 0), 1);
        end
        if (round_reg < 7'd20)
        begin
            f_val = (b_reg & c_reg) | (~b_reg & d_reg);
            k_val = sha1_pkg::K_0;
        end
        else if (round_reg < 7'd40)
        begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = sha1_pkg::K_20;
        end
        else if (round_reg < 7'd60)
        begin
            f_val = (b_reg & c_reg) | (b_reg & d_reg) | (c_reg & d_reg);
            k_val = sha1_pkg::K_40;
        end
        else
        begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = sha1_pkg::K_60;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        pad_next   = pad_reg;
        fin_next   = fin_reg;
        round_next = round_reg;
        count_next = count_reg;
        len_next   = len_reg;
        idx_next   = idx_reg;
        hash_next  = hash_reg;
        sched_next = sched_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        c_next     = c_reg;
        d_next     = d_reg;
        e_next     = e_reg;
        push_en    = 1'b0;
        push_byte  = '0;

        unique case (state_reg)
            sha1_pkg::ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    if (s_axis_tuser)
                    begin
                        push_en   = 1'b1;
                        push_byte = s_axis_tdata;
                        len_next  = len_reg + 64'd8;
                    end
                    fin_next = s_axis_tlast;
                    pad_next = sha1_pkg::PAD_MARK;
                    if (s_axis_tlast)
                    begin
                        state_next = sha1_pkg::ST_PAD;
                    end
                end
            end
            sha1_pkg::ST_PAD:
            begin
                push_en = 1'b1;
                case (pad_reg) inside
                    sha1_pkg::PAD_MARK, sha1_pkg::PAD_ZERO:
                    begin
                        push_byte = (pad_reg == sha1_pkg::PAD_MARK) ?
                                    sha1_pkg::PAD_MARK_BYTE : 8'h00;
                        pad_next  = (count_reg + 6'd1 == sha1_pkg::LEN_BYTE_POS) ?
                                    sha1_pkg::PAD_LEN : sha1_pkg::PAD_ZERO;
                    end
                    sha1_pkg::PAD_LEN:
                    begin
                        push_byte = len_reg[63:56];
                        len_next  = {len_reg[55:0], 8'h00};
                        if (count_reg == sha1_pkg::LAST_BYTE_POS)
                        begin
                            pad_next = sha1_pkg::PAD_DONE;
                        end
                    end
                    default:
                    begin
                        push_en = 1'b0;
                    end
                endcase
            end
            sha1_pkg::ST_ROUND:
            begin
                sched_next = {sched_reg[479:0], w_sel};
                a_next = sha1_pkg::rotl(a_reg, 5) + f_val + e_reg + k_val + w_sel;
                b_next = a_reg;
                c_next = sha1_pkg::rotl(b_reg, 30);
                d_next = c_reg;
                e_next = d_reg;
                round_next = round_reg + 7'd1;
                if (round_reg == 7'(sha1_pkg::NUM_ROUNDS - 1))
                begin
                    state_next = sha1_pkg::ST_ADD;
                end
            end
            sha1_pkg::ST_ADD:
            begin
                hash_next[0] = hash_reg[0] + a_reg;
                hash_next[1] = hash_reg[1] + b_reg;
                hash_next[2] = hash_reg[2] + c_reg;
                hash_next[3] = hash_reg[3] + d_reg;
                hash_next[4] = hash_reg[4] + e_reg;
                if (!fin_reg)
                begin
                    state_next = sha1_pkg::ST_IDLE;
                end
                else if (pad_reg == sha1_pkg::PAD_DONE)
                begin
                    state_next = sha1_pkg::ST_OUT;
                    idx_next   = '0;
                end
                else
                begin
                    state_next = sha1_pkg::ST_PAD;
                end
            end
            sha1_pkg::ST_OUT:
            begin
                if (m_axis_tready)
                begin
                    idx_next = idx_reg + 3'd1;
                    if (idx_reg == 3'(sha1_pkg::NUM_WORDS - 1))
                    begin
                        state_next = sha1_pkg::ST_IDLE;
                        hash_next  = sha1_pkg::H_INIT;
                        len_next   = '0;
                        fin_next   = 1'b0;
                        idx_next   = '0;
                    end
                end
            end
            default:
            begin
                state_next = sha1_pkg::ST_IDLE;
            end
        endcase

        // byte path shared by message and padding; a full block starts the rounds
        if (push_en)
        begin
            sched_next = {sched_reg[503:0], push_byte};
            count_next = count_reg + 6'd1;
            if (count_reg == sha1_pkg::LAST_BYTE_POS)
            begin
                state_next = sha1_pkg::ST_ROUND;
                round_next = '0;
                a_next     = hash_reg[0];
                b_next     = hash_reg[1];
                c_next     = hash_reg[2];
                d_next     = hash_reg[3];
                e_next     = hash_reg[4];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sha1_pkg::ST_IDLE;
            pad_reg   <= sha1_pkg::PAD_MARK;
            fin_reg   <= 1'b0;
            round_reg <= '0;
            count_reg <= '0;
            len_reg   <= '0;
            idx_reg   <= '0;
            hash_reg  <= sha1_pkg::H_INIT;
        end
        else
        begin
            state_reg <= state_next;
            pad_reg   <= pad_next;
            fin_reg   <= fin_next;
            round_reg <= round_next;
            count_reg <= count_next;
            len_reg   <= len_next;
            idx_reg   <= idx_next;
            hash_reg  <= hash_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sched_reg <= sched_next;
        a_reg     <= a_next;
        b_reg     <= b_next;
        c_reg     <= c_next;
        d_reg     <= d_next;
        e_reg     <= e_next;
    end

    assign s_axis_tready = (state_reg == sha1_pkg::ST_IDLE);
    assign m_axis_tvalid = (state_reg == sha1_pkg::ST_OUT);
    assign m_axis_tdata  = hash_reg[idx_reg];
    assign m_axis_tuser  = idx_reg;
    assign m_axis_tlast  = (idx_reg == 3'(sha1_pkg::NUM_WORDS - 1));

    `ASSERT_ALWAYS(a_one_side, !(s_axis_tready && m_axis_tvalid), "both sides open")
    `ASSERT_IMPLIES(a_round, state_reg == sha1_pkg::ST_ROUND, round_reg < 7'd80, "overrun")
    `ASSERT_IMPLIES(a_out_aligned, m_axis_tvalid, count_reg == 6'd0, "digest mid-block")
    `ASSERT_IMPLIES(a_out_padded, m_axis_tvalid, pad_reg == sha1_pkg::PAD_DONE, "no padding")
    `ASSERT_NEXT(a_restart, m_axis_tlast && m_axis_tready, s_axis_tready, "no restart")

endmodule

// File: test/tb_sha1_message_digest_unit.sv
`timescale 1ns / 1ps

module tb_sha1_message_digest_unit;

    localparam int CYCLE_LIMIT = 400000;
    localparam int RAND_ITEMS  = 140;

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  index;
        logic        last;
    } digest_word_t;

    typedef struct {
        logic [7:0]   data;
        bit           valid;
        bit           last;
        bit           known;
        logic [159:0] digest;
    } dir_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        s_axis_tuser;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;
    logic        m_axis_tlast;

    sha1_message_digest_unit u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // expected digest words, oldest first
    digest_word_t digest_q[$];
    dir_row_t     dir_rows[$];

    // predictor state
    logic [31:0] chain_words [5];
    logic [31:0] msg_sched [16];
    logic [5:0]  blk_pos;
    logic [63:0] msg_bits;

    int  n_mismatch;
    int  n_words;
    int  n_msgs;
    int  n_bytes;
    int  n_ignored;
    int  cycle_cnt;
    int  stall_left;
    bit  quiet;

    initial clk = 1'b0;
    always #2 clk = ~clk;

    function automatic void sha_clear();
        chain_words[0] = sha1_pkg::H0_INIT;
        chain_words[1] = sha1_pkg::H1_INIT;
        chain_words[2] = sha1_pkg::H2_INIT;
        chain_words[3] = sha1_pkg::H3_INIT;
        chain_words[4] = sha1_pkg::H4_INIT;
        blk_pos  = '0;
        msg_bits = '0;
    endfunction

    function automatic void sha_compress();
        logic [31:0] a, b, c, d, e, f, k, w, t;
        int r, s;
        a = chain_words[0];
        b = chain_words[1];
        c = chain_words[2];
        d = chain_words[3];
        e = chain_words[4];
        for (r = 0; r < 80; r++)
        begin
            s = r % 16;
            if (r >= 16)
            begin
                w = msg_sched[(s + 13) % 16] ^ msg_sched[(s + 8) % 16]
                  ^ msg_sched[(s + 2) % 16] ^ msg_sched[s];
                msg_sched[s] = {w[30:0], w[31]};
            end
            w = msg_sched[s];
            if (r < 20)
            begin
                f = (b & c) | (~b & d);
                k = sha1_pkg::K_0;
            end
            else if (r < 40)
            begin
                f = b ^ c ^ d;
                k = sha1_pkg::K_20;
            end
            else if (r < 60)
            begin
                f = (b & c) | (b & d) | (c & d);
                k = sha1_pkg::K_40;
            end
            else
            begin
                f = b ^ c ^ d;
                k = sha1_pkg::K_60;
            end
            t = {a[26:0], a[31:27]} + f + e + k + w;
            e = d;
            d = c;
            c = {b[1:0], b[31:2]};
            b = a;
            a = t;
        end
        chain_words[0] += a;
        chain_words[1] += b;
        chain_words[2] += c;
        chain_words[3] += d;
        chain_words[4] += e;
    endfunction

    function automatic void sha_absorb(input logic [7:0] b);
        msg_sched[blk_pos[5:2]][8 * (3 - blk_pos[1:0]) +: 8] = b;
        blk_pos++;
        if (blk_pos == 6'd0)
            sha_compress();
    endfunction

    // returns 1 when the item closes a message; dig holds H0..H4, H0 on top
    function automatic bit sha_step(input logic [7:0] data, input bit valid,
                                    input bit last, output logic [159:0] dig);
        logic [63:0] len;
        int i;
        dig = '0;
        if (valid)
        begin
            sha_absorb(data);
            msg_bits += 64'd8;
        end
        if (!last)
            return 1'b0;
        len = msg_bits;
        sha_absorb(sha1_pkg::PAD_MARK_BYTE);
        while (blk_pos != sha1_pkg::LEN_BYTE_POS)
            sha_absorb(8'h00);
        for (i = 0; i < 8; i++)
            sha_absorb(len[63 - 8 * i -: 8]);
        dig = {chain_words[0], chain_words[1], chain_words[2],
               chain_words[3], chain_words[4]};
        sha_clear();
        return 1'b1;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 19);
        if (r < 14)
            return $urandom_range(1, 3);
        else if (r < 19)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] exp_val);
        $display("[%0t] mismatch on %s: got %h, expected %h", $time, what, got, exp_val);
        n_mismatch++;
    endtask

    task automatic send_item(input logic [7:0] data, input bit valid, input bit last,
                             input bit known, input logic [159:0] known_dig);
        int gap;
        int i;
        logic [159:0] dig;
        digest_word_t dw;
        gap = (!quiet && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
        if (gap > 0)
        begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tdata  = data;
        s_axis_tuser  = valid;
        s_axis_tlast  = last;
        s_axis_tvalid = 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        if (sha_step(data, valid, last, dig))
        begin
            if (known)
                dig = known_dig;
            for (i = 0; i < 5; i++)
            begin
                dw.word  = dig[159 - 32 * i -: 32];
                dw.index = i[2:0];
                dw.last  = (i == 4);
                digest_q.insert(digest_q.size(), dw);
            end
            n_msgs++;
        end
        if (valid)
            n_bytes++;
        else if (!last)
            n_ignored++;
        @(negedge clk);
    endtask

    task automatic add_row(input logic [7:0] data, input bit valid, input bit last,
                           input bit known, input logic [159:0] dig);
        dir_row_t row;
        row.data   = data;
        row.valid  = valid;
        row.last   = last;
        row.known  = known;
        row.digest = dig;
        dir_rows.insert(dir_rows.size(), row);
    endtask

    task automatic drain_digests();
        while (digest_q.size() != 0)
            @(negedge clk);
    endtask

    // receiver stalls
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            m_axis_tready = 1'b0;
            stall_left--;
        end
        else
        begin
            m_axis_tready = 1'b1;
            if (!quiet && $urandom_range(0, 5) == 0)
                stall_left = pick_gap();
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (digest_q.size() == 0)
            begin
                report_mismatch("unexpected digest_word", m_axis_tdata, 32'h0);
            end
            else
            begin
                if (m_axis_tdata !== digest_q[0].word)
                    report_mismatch("digest_word", m_axis_tdata, digest_q[0].word);
                if (m_axis_tuser !== digest_q[0].index)
                    report_mismatch("word_index", 32'(m_axis_tuser),
                                    32'(digest_q[0].index));
                if (m_axis_tlast !== digest_q[0].last)
                    report_mismatch("last_word", 32'(m_axis_tlast),
                                    32'(digest_q[0].last));
                void'(digest_q.pop_front());
                n_words++;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d digest words pending",
                     cycle_cnt, digest_q.size());
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin
        logic [159:0] empty_dig;
        logic [159:0] abc_dig;
        int len;
        int i;
        int rand_items;
        bit end_invalid;
        int sel;

        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        s_axis_tlast  = 1'b0;
        m_axis_tready = 1'b0;
        n_mismatch    = 0;
        n_words       = 0;
        n_msgs        = 0;
        n_bytes       = 0;
        n_ignored     = 0;
        cycle_cnt     = 0;
        stall_left    = 0;
        quiet         = 1'b0;
        rand_items    = 0;
        sha_clear();

        empty_dig = 160'hda39a3ee_5e6b4b0d_3255bfef_95601890_afd80709;
        abc_dig   = 160'ha9993e36_4706816a_ba3e2571_7850c26c_9cd0d89d;

        // empty message
        add_row(8'h00, 1'b0, 1'b1, 1'b1, empty_dig);
        // "abc"
        add_row(8'h61, 1'b1, 1'b0, 1'b0, '0);
        add_row(8'h62, 1'b1, 1'b0, 1'b0, '0);
        add_row(8'h63, 1'b1, 1'b1, 1'b1, abc_dig);
        // "abc" with an ignored transaction inside
        add_row(8'h61, 1'b1, 1'b0, 1'b0, '0);
        add_row(8'hff, 1'b0, 1'b0, 1'b0, '0);
        add_row(8'h62, 1'b1, 1'b0, 1'b0, '0);
        add_row(8'h63, 1'b1, 1'b1, 1'b1, abc_dig);
        // "abc" closed by a byte-less end
        add_row(8'h61, 1'b1, 1'b0, 1'b0, '0);
        add_row(8'h62, 1'b1, 1'b0, 1'b0, '0);
        add_row(8'h63, 1'b1, 1'b0, 1'b0, '0);
        add_row(8'h00, 1'b0, 1'b1, 1'b1, abc_dig);
        // byte extremes
        add_row(8'h00, 1'b1, 1'b0, 1'b0, '0);
        add_row(8'hff, 1'b1, 1'b1, 1'b0, '0);
        add_row(8'hff, 1'b1, 1'b0, 1'b0, '0);
        add_row(8'hff, 1'b0, 1'b1, 1'b0, '0);
        add_row(8'h80, 1'b1, 1'b1, 1'b0, '0);
        add_row(8'h7f, 1'b1, 1'b1, 1'b0, '0);
        add_row(8'h01, 1'b1, 1'b1, 1'b0, '0);

        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (dir_rows[r])
            send_item(dir_rows[r].data, dir_rows[r].valid, dir_rows[r].last,
                      dir_rows[r].known, dir_rows[r].digest);
        s_axis_tvalid = 1'b0;
        drain_digests();

        while (rand_items < RAND_ITEMS)
        begin
            sel = $urandom_range(0, 9);
            if (sel < 5)
                len = $urandom_range(0, 8);
            else if (sel < 7)
                len = $urandom_range(54, 57);
            else if (sel < 8)
                len = $urandom_range(62, 66);
            else if (sel < 9)
                len = $urandom_range(9, 40);
            else
                len = $urandom_range(118, 122);
            if (len > RAND_ITEMS - rand_items)
                len = RAND_ITEMS - rand_items;
            quiet = ($urandom_range(0, 4) == 0);
            end_invalid = (len == 0) || ($urandom_range(0, 3) == 0);
            for (i = 0; i < len; i++)
            begin
                if ($urandom_range(0, 7) == 0)
                begin
                    send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0, '0);
                    rand_items++;
                end
                send_item(8'($urandom_range(0, 255)), 1'b1,
                          (i == len - 1) && !end_invalid, 1'b0, '0);
                rand_items++;
            end
            if (end_invalid)
            begin
                send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1, 1'b0, '0);
                rand_items++;
            end
            if ($urandom_range(0, 5) == 0)
            begin
                s_axis_tvalid = 1'b0;
                drain_digests();
            end
        end
        s_axis_tvalid = 1'b0;
        quiet = 1'b0;

        drain_digests();
        repeat (50) @(posedge clk);

        $display("Covered %0d messages, %0d message bytes, %0d ignored transactions",
                 n_msgs, n_bytes, n_ignored);
        $display("Checked %0d digest words, %0d mismatches", n_words, n_mismatch);
        if (n_mismatch == 0 && digest_q.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// File: files.f
+incdir+src
src/sha1_pkg.sv
src/sha1_message_digest_unit.sv
test/tb_sha1_message_digest_unit.sv
